// ----- hdl/kttk_pkg.sv -----
// Package for the kana to halfwidth katakana converter: types, constants and lookup functions.
`default_nettype none

package kttk_pkg;

   localparam int UNIT_W      = 16;
   localparam int UNITS_W     = 17;
   localparam int IDX_W       = 7;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [UNIT_W-1:0]  HIRA_FIRST = 16'h3041;
   localparam logic [UNIT_W-1:0]  HIRA_LAST  = 16'h3093;
   localparam logic [UNIT_W-1:0]  KATA_FIRST = 16'h30A1;
   localparam logic [UNIT_W-1:0]  KATA_LAST  = 16'h30F6;
   localparam logic [UNIT_W-1:0]  MARK_DKT   = 16'hFF9E;
   localparam logic [UNIT_W-1:0]  MARK_HDK   = 16'hFF9F;
   localparam logic [UNIT_W-1:0]  COUNT_MAX  = 16'hFFFF;
   localparam logic [UNITS_W-1:0] UNITS_MAX  = 17'h1FFFF;

   // Trailing sound mark that goes with a table entry.
   typedef enum logic [1:0] {
      SND_NONE   = 2'd0,
      SND_VOICED = 2'd1,
      SND_SEMI   = 2'd2
   } snd_type;

   typedef struct packed {
      logic [UNIT_W-1:0] first;
      snd_type           snd;
   } kana_type;

   // One classified request as it waits for the output side.
   typedef struct packed {
      logic [UNIT_W-1:0] unit;
      snd_type           snd;
      logic              dropped;
      logic              eos;
      logic [UNIT_W-1:0] count;
   } entry_type;

   function automatic logic [UNIT_W-1:0] punct_map(input logic [UNIT_W-1:0] u);
      logic [UNIT_W-1:0] r;
      case (u)
         16'h30FC: r = 16'hFF70;
         16'h309B: r = 16'hFF9E;
         16'h309C: r = 16'hFF9F;
         16'h3002: r = 16'hFF61;
         16'h300C: r = 16'hFF62;
         16'h300D: r = 16'hFF63;
         16'h3001: r = 16'hFF64;
         16'h30FB: r = 16'hFF65;
         default:  r = 16'h0000;
      endcase
      return r;
   endfunction

   function automatic kana_type kana_lookup(input logic [IDX_W-1:0] idx);
      kana_type r;
      case (idx)
         7'd0:  r = '{16'hFF67, SND_NONE};
         7'd1:  r = '{16'hFF71, SND_NONE};
         7'd2:  r = '{16'hFF68, SND_NONE};
         7'd3:  r = '{16'hFF72, SND_NONE};
         7'd4:  r = '{16'hFF69, SND_NONE};
         7'd5:  r = '{16'hFF73, SND_NONE};
         7'd6:  r = '{16'hFF6A, SND_NONE};
         7'd7:  r = '{16'hFF74, SND_NONE};
         7'd8:  r = '{16'hFF6B, SND_NONE};
         7'd9:  r = '{16'hFF75, SND_NONE};
         7'd10: r = '{16'hFF76, SND_NONE};
         7'd11: r = '{16'hFF76, SND_VOICED};
         7'd12: r = '{16'hFF77, SND_NONE};
         7'd13: r = '{16'hFF77, SND_VOICED};
         7'd14: r = '{16'hFF78, SND_NONE};
         7'd15: r = '{16'hFF78, SND_VOICED};
         7'd16: r = '{16'hFF79, SND_NONE};
         7'd17: r = '{16'hFF79, SND_VOICED};
         7'd18: r = '{16'hFF7A, SND_NONE};
         7'd19: r = '{16'hFF7A, SND_VOICED};
         7'd20: r = '{16'hFF7B, SND_NONE};
         7'd21: r = '{16'hFF7B, SND_VOICED};
         7'd22: r = '{16'hFF7C, SND_NONE};
         7'd23: r = '{16'hFF7C, SND_VOICED};
         7'd24: r = '{16'hFF7D, SND_NONE};
         7'd25: r = '{16'hFF7D, SND_VOICED};
         7'd26: r = '{16'hFF7E, SND_NONE};
         7'd27: r = '{16'hFF7E, SND_VOICED};
         7'd28: r = '{16'hFF7F, SND_NONE};
         7'd29: r = '{16'hFF7F, SND_VOICED};
         7'd30: r = '{16'hFF80, SND_NONE};
         7'd31: r = '{16'hFF80, SND_VOICED};
         7'd32: r = '{16'hFF81, SND_NONE};
         7'd33: r = '{16'hFF81, SND_VOICED};
         7'd34: r = '{16'hFF6F, SND_NONE};
         7'd35: r = '{16'hFF82, SND_NONE};
         7'd36: r = '{16'hFF82, SND_VOICED};
         7'd37: r = '{16'hFF83, SND_NONE};
         7'd38: r = '{16'hFF83, SND_VOICED};
         7'd39: r = '{16'hFF84, SND_NONE};
         7'd40: r = '{16'hFF84, SND_VOICED};
         7'd41: r = '{16'hFF85, SND_NONE};
         7'd42: r = '{16'hFF86, SND_NONE};
         7'd43: r = '{16'hFF87, SND_NONE};
         7'd44: r = '{16'hFF88, SND_NONE};
         7'd45: r = '{16'hFF89, SND_NONE};
         7'd46: r = '{16'hFF8A, SND_NONE};
         7'd47: r = '{16'hFF8A, SND_VOICED};
         7'd48: r = '{16'hFF8A, SND_SEMI};
         7'd49: r = '{16'hFF8B, SND_NONE};
         7'd50: r = '{16'hFF8B, SND_VOICED};
         7'd51: r = '{16'hFF8B, SND_SEMI};
         7'd52: r = '{16'hFF8C, SND_NONE};
         7'd53: r = '{16'hFF8C, SND_VOICED};
         7'd54: r = '{16'hFF8C, SND_SEMI};
         7'd55: r = '{16'hFF8D, SND_NONE};
         7'd56: r = '{16'hFF8D, SND_VOICED};
         7'd57: r = '{16'hFF8D, SND_SEMI};
         7'd58: r = '{16'hFF8E, SND_NONE};
         7'd59: r = '{16'hFF8E, SND_VOICED};
         7'd60: r = '{16'hFF8E, SND_SEMI};
         7'd61: r = '{16'hFF8F, SND_NONE};
         7'd62: r = '{16'hFF90, SND_NONE};
         7'd63: r = '{16'hFF91, SND_NONE};
         7'd64: r = '{16'hFF92, SND_NONE};
         7'd65: r = '{16'hFF93, SND_NONE};
         7'd66: r = '{16'hFF6C, SND_NONE};
         7'd67: r = '{16'hFF94, SND_NONE};
         7'd68: r = '{16'hFF6D, SND_NONE};
         7'd69: r = '{16'hFF95, SND_NONE};
         7'd70: r = '{16'hFF6E, SND_NONE};
         7'd71: r = '{16'hFF96, SND_NONE};
         7'd72: r = '{16'hFF97, SND_NONE};
         7'd73: r = '{16'hFF98, SND_NONE};
         7'd74: r = '{16'hFF99, SND_NONE};
         7'd75: r = '{16'hFF9A, SND_NONE};
         7'd76: r = '{16'hFF9B, SND_NONE};
         7'd77: r = '{16'h30EE, SND_NONE};
         7'd78: r = '{16'hFF9C, SND_NONE};
         7'd79: r = '{16'h30F0, SND_NONE};
         7'd80: r = '{16'h30F1, SND_NONE};
         7'd81: r = '{16'hFF66, SND_NONE};
         7'd82: r = '{16'hFF9D, SND_NONE};
         7'd83: r = '{16'hFF73, SND_VOICED};
         7'd84: r = '{16'h30F5, SND_NONE};
         7'd85: r = '{16'h30F6, SND_NONE};
         default: r = '{16'h0000, SND_NONE};
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/kana_to_halfwidth_katakana.sv -----
// Top level of the fullwidth kana to halfwidth katakana converter.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  code_unit
//   rsp_      out        rsp_valid/rsp_stall  out_unit, last_of_run, dropped,
//                                             end_of_string, kana_count
//   csr_      in         csr_wr_en            output_limit (csr_wr_data)
//
// A request that yields one unit gives one result; one that yields a unit plus
// a sound mark gives two, as the output register moves one result per cycle
// while rsp_stall is low. Requests pass through a queue slot to the output register.
// A two-entry queue sits between the classifier and the output side; req_stall
// is high while it is full. Reset is synchronous and restores a limit of 65535
// and zero counts. A stalled result holds in the output register.
`default_nettype none

module kana_to_halfwidth_katakana (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_wr_en,
   input  wire logic [kttk_pkg::UNIT_W-1:0] csr_wr_data,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [kttk_pkg::UNIT_W-1:0] req_code_unit,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [kttk_pkg::UNIT_W-1:0]    rsp_out_unit,
   output logic                           rsp_last_of_run,
   output logic                           rsp_dropped,
   output logic                           rsp_end_of_string,
   output logic [kttk_pkg::UNIT_W-1:0]    rsp_kana_count
);
   import kttk_pkg::*;

   logic      q_full, push, pop, head_valid;
   entry_type push_entry, head_entry;

   kttk_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_valid     (req_valid),
      .req_code_unit (req_code_unit),
      .req_stall     (req_stall),
      .q_full        (q_full),
      .push          (push),
      .push_entry    (push_entry)
   );

   kttk_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .q_full     (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   kttk_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_entry        (head_entry),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_unit      (rsp_out_unit),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_dropped       (rsp_dropped),
      .rsp_end_of_string (rsp_end_of_string),
      .rsp_kana_count    (rsp_kana_count)
   );

endmodule

`default_nettype wire

// ----- hdl/kttk_front.sv -----
// Front side: limit register, request classification and the running counts.
`default_nettype none

module kttk_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_wr_en,
   input  wire logic [kttk_pkg::UNIT_W-1:0] csr_wr_data,
   input  wire logic                      req_valid,
   input  wire logic [kttk_pkg::UNIT_W-1:0] req_code_unit,
   output logic                           req_stall,
   input  wire logic                      q_full,
   output logic                           push,
   output kttk_pkg::entry_type            push_entry
);
   import kttk_pkg::*;

   logic [UNIT_W-1:0]  limit_ff, limit_in;
   logic [UNITS_W-1:0] units_ff, units_in;
   logic [UNIT_W-1:0]  total_ff, total_in;

   logic               is_zero, over, is_kata, is_hira, conv, two;
   logic [UNIT_W-1:0]  punct, kata_off, hira_off, first, total_inc;
   logic [IDX_W-1:0]   idx;
   kana_type           kana;
   snd_type            snd;
   logic [UNITS_W:0]   units_sum;

   assign req_stall = q_full;
   assign push      = req_valid && !q_full;

   always_comb begin
      is_zero  = (req_code_unit == '0);
      over     = (units_ff > {1'b0, limit_ff});
      punct    = punct_map(req_code_unit);
      is_kata  = (req_code_unit >= KATA_FIRST) && (req_code_unit <= KATA_LAST);
      is_hira  = (req_code_unit >= HIRA_FIRST) && (req_code_unit <= HIRA_LAST);
      kata_off = req_code_unit - KATA_FIRST;
      hira_off = req_code_unit - HIRA_FIRST;
      idx      = is_kata ? kata_off[IDX_W-1:0] : hira_off[IDX_W-1:0];
      kana     = kana_lookup(idx);

      // Punctuation takes priority, then katakana, then hiragana.
      conv  = 1'b1;
      snd   = SND_NONE;
      first = req_code_unit;
      if (punct != '0) begin
         first = punct;
      end else if (is_kata || is_hira) begin
         first = kana.first;
         snd   = kana.snd;
      end else begin
         conv = 1'b0;
      end

      two       = (snd != SND_NONE);
      total_inc = (conv && total_ff != COUNT_MAX) ? total_ff + 16'd1 : total_ff;
      units_sum = {1'b0, units_ff} + (two ? 18'd2 : 18'd1);

      push_entry = '{unit: first, snd: snd, dropped: 1'b0, eos: 1'b0, count: total_inc};
      units_in   = units_ff;
      total_in   = total_ff;
      if (is_zero) begin
         push_entry = '{unit: '0, snd: SND_NONE, dropped: 1'b0, eos: 1'b1, count: total_ff};
         if (push) begin
            units_in = '0;
            total_in = '0;
         end
      end else if (over) begin
         push_entry = '{unit: '0, snd: SND_NONE, dropped: 1'b1, eos: 1'b0, count: total_ff};
      end else if (push) begin
         total_in = total_inc;
         units_in = (units_sum > {1'b0, UNITS_MAX}) ? UNITS_MAX : units_sum[UNITS_W-1:0];
      end

      limit_in = csr_wr_en ? csr_wr_data : limit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= COUNT_MAX;
         units_ff <= '0;
         total_ff <= '0;
      end else begin
         limit_ff <= limit_in;
         units_ff <= units_in;
         total_ff <= total_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/kttk_queue.sv -----
// Short queue of classified requests between the front and back sides.
`default_nettype none

module kttk_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire kttk_pkg::entry_type push_entry,
   output logic                     q_full,
   input  wire logic                pop,
   output logic                     head_valid,
   output kttk_pkg::entry_type      head_entry
);
   import kttk_pkg::*;

   entry_type           slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign q_full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slots_ff[rd_ptr_ff];

   always_comb begin
      do_push   = push && !q_full;
      do_pop    = pop && head_valid;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/kttk_back.sv -----
// Back side: expands each queued request into one or two results in the output register.
`default_nettype none

module kttk_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      head_valid,
   input  wire kttk_pkg::entry_type       head_entry,
   output logic                           pop,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [kttk_pkg::UNIT_W-1:0]    rsp_out_unit,
   output logic                           rsp_last_of_run,
   output logic                           rsp_dropped,
   output logic                           rsp_end_of_string,
   output logic [kttk_pkg::UNIT_W-1:0]    rsp_kana_count
);
   import kttk_pkg::*;

   logic              valid_ff, valid_in;
   logic              phase_ff, phase_in;
   logic [UNIT_W-1:0] unit_ff, unit_in;
   logic              last_ff, last_in;
   logic              drop_ff, drop_in;
   logic              eos_ff, eos_in;
   logic [UNIT_W-1:0] count_ff, count_in;
   logic              load;
   logic [UNIT_W-1:0] mark;

   always_comb begin
      case (head_entry.snd)
         SND_VOICED: mark = MARK_DKT;
         SND_SEMI:   mark = MARK_HDK;
         default:    mark = '0;
      endcase

      load     = !valid_ff || !rsp_stall;
      pop      = 1'b0;
      valid_in = valid_ff;
      phase_in = phase_ff;
      unit_in  = unit_ff;
      last_in  = last_ff;
      drop_in  = drop_ff;
      eos_in   = eos_ff;
      count_in = count_ff;

      if (load) begin
         valid_in = 1'b0;
         if (phase_ff) begin
            // Second half of a two-unit entry: the sound mark.
            valid_in = 1'b1;
            unit_in  = mark;
            last_in  = 1'b1;
            drop_in  = 1'b0;
            eos_in   = 1'b0;
            count_in = head_entry.count;
            phase_in = 1'b0;
            pop      = 1'b1;
         end else if (head_valid) begin
            valid_in = 1'b1;
            unit_in  = head_entry.unit;
            drop_in  = head_entry.dropped;
            eos_in   = head_entry.eos;
            count_in = head_entry.count;
            if (head_entry.snd != SND_NONE) begin
               last_in  = 1'b0;
               phase_in = 1'b1;
            end else begin
               last_in = 1'b1;
               pop     = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      unit_ff  <= unit_in;
      last_ff  <= last_in;
      drop_ff  <= drop_in;
      eos_ff   <= eos_in;
      count_ff <= count_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_out_unit      = unit_ff;
   assign rsp_last_of_run   = last_ff;
   assign rsp_dropped       = drop_ff;
   assign rsp_end_of_string = eos_ff;
   assign rsp_kana_count    = count_ff;

endmodule

`default_nettype wire

// ----- hdl/kttk_checker.sv -----
// Port-level checker for the converter and its bind to the top level.
`default_nettype none

module kttk_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_stall,
   input wire logic [kttk_pkg::UNIT_W-1:0] rsp_out_unit,
   input wire logic                        rsp_last_of_run,
   input wire logic                        rsp_dropped,
   input wire logic                        rsp_end_of_string,
   input wire logic [kttk_pkg::UNIT_W-1:0] rsp_kana_count
);
   import kttk_pkg::*;

   // A stalled result stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_unit) && $stable(rsp_kana_count))
      else $error("stalled response changed");

   // Nothing comes out in the cycle after reset.
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A terminator is a single zero result that is never a drop.
   a_eos_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_string |->
         rsp_last_of_run && !rsp_dropped && rsp_out_unit == '0)
      else $error("malformed terminator");

   // A dropped request gives a single zero result.
   a_drop_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dropped |-> rsp_last_of_run && rsp_out_unit == '0)
      else $error("malformed drop");

   // The sound mark follows its base unit in the very next cycle.
   a_mark_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_of_run |=>
         rsp_valid && rsp_last_of_run &&
         (rsp_out_unit == MARK_DKT || rsp_out_unit == MARK_HDK))
      else $error("sound mark did not follow its base unit");

endmodule

bind kana_to_halfwidth_katakana kttk_checker u_checker (.*);

`default_nettype wire
